// ===== rtl/mpc_pkg.sv =====
// Package: constants, types and float helpers for the max pool clamp block.
package mpc_pkg;
  localparam int unsigned MaxChannels = 1024;
  localparam int unsigned MaxWindow   = 4096;
  localparam int unsigned ChW  = $clog2(MaxChannels);
  localparam int unsigned WinW = $clog2(MaxWindow);
  localparam logic [31:0] QNan = 32'h7FC0_0000;

  // register indexes
  localparam logic [1:0] RegWindow   = 2'd0;
  localparam logic [1:0] RegChannels = 2'd1;
  localparam logic [1:0] RegOutMin   = 2'd2;
  localparam logic [1:0] RegOutMax   = 2'd3;

  typedef struct packed {
    logic            first;
    logic            emit;
    logic            last_chan;
    logic [ChW-1:0]  addr;
  } ctl_t;

  function automatic logic is_nan(input logic [31:0] b);
    return b[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] b);
    return b[31] ? ~b : (b | 32'h8000_0000);
  endfunction

  function automatic logic [31:0] fmax(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return QNan;
    return (order_key(a) >= order_key(b)) ? a : b;
  endfunction

  function automatic logic [31:0] fmin(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return QNan;
    return (order_key(a) <= order_key(b)) ? a : b;
  endfunction
endpackage

// ===== rtl/mpc_ram.sv =====
// Simple dual-port RAM with registered read.
module mpc_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/mpc_seq.sv =====
// Position counters: window and channel positions, per-item control.
module mpc_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [12:0]               window_size_i,
  input  logic [10:0]               channel_count_i,
  output mpc_pkg::ctl_t             ctl_o
);
  import mpc_pkg::*;

  logic [WinW-1:0] win_q, win_d;
  logic [ChW-1:0]  ch_q, ch_d;
  logic [WinW:0]   wlim;
  logic [ChW:0]    clim;
  logic            last_elem, last_chan;

  // effective limits: zero reads as one, large values saturate
  always_comb begin
    if (window_size_i == '0) wlim = (WinW+1)'(1);
    else if (32'(window_size_i) > MaxWindow) wlim = (WinW+1)'(MaxWindow);
    else wlim = (WinW+1)'(window_size_i);
    if (channel_count_i == '0) clim = (ChW+1)'(1);
    else if (32'(channel_count_i) > MaxChannels) clim = (ChW+1)'(MaxChannels);
    else clim = (ChW+1)'(channel_count_i);
  end

  assign last_elem = ({1'b0, win_q} + (WinW+1)'(1)) >= wlim;
  assign last_chan = ({1'b0, ch_q} + (ChW+1)'(1)) >= clim;

  always_comb begin
    ctl_o.first     = (win_q == '0);
    ctl_o.emit      = last_elem;
    ctl_o.last_chan = last_chan;
    ctl_o.addr      = ch_q;
  end

  // advance positions per item
  always_comb begin
    win_d = win_q;
    ch_d  = ch_q;
    if (adv_i) begin
      if (last_chan) begin
        ch_d  = '0;
        win_d = last_elem ? '0 : win_q + WinW'(1);
      end else begin
        ch_d = ch_q + ChW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      ch_q  <= '0;
    end else begin
      win_q <= win_d;
      ch_q  <= ch_d;
    end
  end
endmodule

// ===== rtl/max_pool_clamp_f32.sv =====
// Top level of the single-precision max pooling block with output clamp.
// One sample is taken per cycle, back to back, unless the input is stalled.
// At its accept edge a sample issues the read of its channel's running
// maximum from a 1024-entry synchronous RAM. In the next cycle the float
// maximum is taken, and on the window's last element it is clamped into a
// two-entry output queue. The maximum is registered in the write-back stage
// and then written to the RAM, and a channel that is still waiting for its
// write back is forwarded. The input is stalled only while the output queue
// could overflow.
module max_pool_clamp_f32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        sample_valid_i,
  output logic        sample_stall_o,
  input  logic [31:0] sample_i,
  output logic        result_valid_o,
  input  logic        result_stall_i,
  output logic [31:0] pooled_value_o,
  output logic        last_of_pixel_o
);
  import mpc_pkg::*;

  logic [12:0] window_size_q;
  logic [10:0] channel_count_q;
  logic [31:0] out_min_q, out_max_q;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q   <= 13'd1;
      channel_count_q <= 11'd1;
      out_min_q       <= 32'hFF80_0000;
      out_max_q       <= 32'h7F80_0000;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegWindow:   window_size_q   <= pwdata[12:0];
        RegChannels: channel_count_q <= pwdata[10:0];
        RegOutMin:   out_min_q       <= pwdata;
        RegOutMax:   out_max_q       <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      RegWindow:   prdata = {19'd0, window_size_q};
      RegChannels: prdata = {21'd0, channel_count_q};
      RegOutMin:   prdata = out_min_q;
      RegOutMax:   prdata = out_max_q;
      default:     prdata = '0;
    endcase
  end

  logic  acc;
  ctl_t  ctl;

  mpc_seq u_seq (
    .clk_i, .rst_ni, .adv_i(acc),
    .window_size_i(window_size_q), .channel_count_i(channel_count_q),
    .ctl_o(ctl)
  );

  // stage 1 registers
  logic        s1_v_q;
  ctl_t        s1_ctl_q;
  logic [31:0] s1_x_q;
  // stage 2 (write back) registers
  logic        wb_v_q;
  logic [ChW-1:0] wb_addr_q;
  logic [31:0] wb_data_q;
  logic [31:0] rd_data, old_val, m;

  mpc_ram #(.Depth(MaxChannels), .Width(32)) u_ram (
    .clk_i, .we_i(wb_v_q), .waddr_i(wb_addr_q), .wdata_i(wb_data_q),
    .re_i(acc), .raddr_i(ctl.addr), .rdata_o(rd_data)
  );

  // forward the just-written value for a same-channel follow-on
  logic fwd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fwd_q <= 1'b0;
    else if (acc) fwd_q <= wb_v_q && (wb_addr_q == ctl.addr);
  end
  logic [31:0] fwd_data_q;
  always_ff @(posedge clk_i) begin
    if (acc) fwd_data_q <= wb_data_q;
  end

  always_comb begin
    if (s1_v_q && wb_v_q && wb_addr_q == s1_ctl_q.addr) old_val = wb_data_q;
    else if (fwd_q) old_val = fwd_data_q;
    else old_val = rd_data;
    m = s1_ctl_q.first ? s1_x_q : fmax(old_val, s1_x_q);
  end

  // output queue, two entries
  logic [1:0]  cnt_q;
  logic        rd_ptr_q, wr_ptr_q;
  logic [32:0] q_mem [2];
  logic        push, pop;

  assign pop  = result_valid_o && !result_stall_i;
  assign push = s1_v_q && s1_ctl_q.emit;
  // stall while stage 1 could fill a full queue
  assign sample_stall_o = (cnt_q == 2'd2) || (cnt_q == 2'd1 && s1_v_q && !pop);
  assign acc = sample_valid_i && !sample_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      wb_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc;
      wb_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ctl_q <= ctl;
      s1_x_q   <= sample_i;
    end
    wb_addr_q <= s1_ctl_q.addr;
    wb_data_q <= m;
    if (push) q_mem[wr_ptr_q] <= {s1_ctl_q.last_chan, fmax(fmin(m, out_max_q), out_min_q)};
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_ptr_q <= 1'b0; wr_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign result_valid_o  = (cnt_q != '0);
  assign pooled_value_o  = q_mem[rd_ptr_q][31:0];
  assign last_of_pixel_o = q_mem[rd_ptr_q][32];
endmodule

// ===== rtl/mpc_checker.sv =====
// Port-level checker for the max pooling block, bound to the top level.
module mpc_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        sample_valid_i,
  input logic        sample_stall_o,
  input logic        result_valid_o,
  input logic        result_stall_i,
  input logic [31:0] pooled_value_o,
  input logic        last_of_pixel_o,
  input logic        pready
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(pooled_value_o)
    && $stable(last_of_pixel_o)) else $error("result changed under stall");
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(sample_valid_i) && !$past(sample_valid_i, 2) && !$past(sample_valid_i, 3)
    && !$past(result_valid_o) |-> !result_valid_o) else $error("result without item");
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && pooled_value_o[30:23] == 8'hFF && pooled_value_o[22:0] != '0
    |-> pooled_value_o == 32'h7FC0_0000) else $error("non-canonical NaN");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |=> !sample_stall_o || $past(sample_valid_i))
    else $error("stall with empty queue");
endmodule

bind max_pool_clamp_f32 mpc_assert u_mpc_assert (.*);

// ===== verif/mpc_checker.sv =====
// Checker for the max pool clamp block: predicts pooled items and compares them.
`timescale 1ns / 1ps
module mpc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        sample_valid_i,
  input  logic        sample_stall_i,
  input  logic [31:0] sample_i,
  input  logic        result_valid_i,
  input  logic        result_stall_i,
  input  logic [31:0] pooled_value_i,
  input  logic        last_of_pixel_i,
  output int          fail_count_o,
  output int          pending_o
);
  import mpc_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } pooled_t;

  pooled_t     pooled_q[$];
  logic [31:0] chan_max[MaxChannels];
  logic [12:0] window_cfg;
  logic [10:0] channels_cfg;
  logic [31:0] clamp_lo;
  logic [31:0] clamp_hi;
  int unsigned win_pos;
  int unsigned chan_pos;
  int          fails;

  function automatic logic nan_bits(input logic [31:0] b);
    return b[30:0] > 31'h7F80_0000;
  endfunction

  // map float bits to an unsigned key that orders like the values, -0 below +0
  function automatic logic [31:0] rank(input logic [31:0] b);
    return b[31] ? ~b : {1'b1, b[30:0]};
  endfunction

  function automatic logic [31:0] float_larger(input logic [31:0] a, input logic [31:0] b);
    if (nan_bits(a) || nan_bits(b)) return QNan;
    return (rank(a) >= rank(b)) ? a : b;
  endfunction

  function automatic logic [31:0] float_smaller(input logic [31:0] a, input logic [31:0] b);
    if (nan_bits(a) || nan_bits(b)) return QNan;
    return (rank(a) <= rank(b)) ? a : b;
  endfunction

  // fold one sample into the running maximum, queue a pooled item on the last element
  task automatic pool_sample(input logic [31:0] x);
    int unsigned wlim;
    int unsigned clim;
    int unsigned idx;
    logic        last_elem;
    logic        last_chan;
    logic [31:0] m;
    pooled_t     item;
    wlim = (window_cfg == 0) ? 1 : (window_cfg > MaxWindow) ? MaxWindow : window_cfg;
    clim = (channels_cfg == 0) ? 1 : (channels_cfg > MaxChannels) ? MaxChannels : channels_cfg;
    last_elem = (win_pos + 1 >= wlim);
    last_chan = (chan_pos + 1 >= clim);
    idx = (chan_pos >= MaxChannels) ? MaxChannels - 1 : chan_pos;
    m = (win_pos == 0) ? x : float_larger(chan_max[idx], x);
    chan_max[idx] = m;
    if (last_elem) begin
      item.value = float_larger(float_smaller(m, clamp_hi), clamp_lo);
      item.last = last_chan;
      pooled_q.push_back(item);
    end
    if (last_chan) begin
      chan_pos = 0;
      win_pos = last_elem ? 0 : win_pos + 1;
    end else begin
      chan_pos = chan_pos + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_t want;
    if (!rst_ni) begin
      pooled_q.delete();
      window_cfg = 13'd1;
      channels_cfg = 11'd1;
      clamp_lo = 32'hFF80_0000;
      clamp_hi = 32'h7F80_0000;
      win_pos = 0;
      chan_pos = 0;
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegWindow:   window_cfg = pwdata[12:0];
          RegChannels: channels_cfg = pwdata[10:0];
          RegOutMin:   clamp_lo = pwdata;
          RegOutMax:   clamp_hi = pwdata;
          default: ;
        endcase
      end
      // compare an accepted pooled item with the oldest prediction
      if (result_valid_i && !result_stall_i) begin
        if (pooled_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected item: value %h last %b", pooled_value_i, last_of_pixel_i);
        end else begin
          want = pooled_q.pop_front();
          if (want.value !== pooled_value_i || want.last !== last_of_pixel_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected value %h last %b, got value %h last %b",
                       want.value, want.last, pooled_value_i, last_of_pixel_i);
          end
        end
      end
      // predict from an accepted sample
      if (sample_valid_i && !sample_stall_i) pool_sample(sample_i);
      fail_count_o <= fails;
      pending_o <= pooled_q.size();
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// Testbench top: clock, reset, stimulus and verdict for the max pool clamp block.
`timescale 1ns / 1ps
module tb_top;
  import mpc_pkg::*;

  localparam int CycleLimit = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        sample_valid_i;
  logic        sample_stall_o;
  logic [31:0] sample_i;
  logic        result_valid_o;
  logic        result_stall_i;
  logic [31:0] pooled_value_o;
  logic        last_of_pixel_o;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          items_sent;
  bit          calm;

  max_pool_clamp_f32 u_dut (.*);

  mpc_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .sample_valid_i, .sample_stall_i(sample_stall_o), .sample_i,
    .result_valid_i(result_valid_o), .result_stall_i,
    .pooled_value_i(pooled_value_o), .last_of_pixel_i(last_of_pixel_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // stall the result side at random, except in calm stretches
  always @(negedge clk_i) begin
    result_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 11);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop the input, drain all pooled items, then let in-flight samples finish
  task automatic settle();
    sample_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic send_sample(input logic [31:0] v);
    while (!calm && $urandom_range(99) < 11) begin
      sample_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i <= v;
    do @(posedge clk_i); while (sample_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  function automatic logic [31:0] rand_float();
    logic s;
    s = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: return {s, 31'h0};
      1: return {s, 31'h7F80_0000};
      2: return {s, 8'hFF, 1'($urandom_range(1)), 22'($urandom)} | 32'h0000_0001;
      3: return {s, 8'h00, 23'($urandom)};
      4, 5: return {s, 8'($urandom_range(8'h7C, 8'h82)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pixels(input int win, input int chans, input int count);
    repeat (win * chans * count) send_sample(rand_float());
  endtask

  initial begin
    logic [31:0] edges[11];
    logic [31:0] zeros[8];
    int win;
    int chans;
    int target;
    edges = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
              32'h8000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF};
    zeros = '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
              32'h4000_0000, 32'h7FC0_0001, 32'h0000_0001, 32'h3F00_0000};
    items_sent = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_valid_i = 1'b0;
    sample_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // field extremes and NaN encodings with reset settings
    foreach (edges[i]) send_sample(edges[i]);
    settle();

    // signed zeros, NaN and subnormal inside a window, clamp to [-0, 1]
    write_reg(RegWindow, 32'd2);
    write_reg(RegChannels, 32'd2);
    write_reg(RegOutMin, 32'h8000_0000);
    write_reg(RegOutMax, 32'h3F80_0000);
    foreach (zeros[i]) send_sample(zeros[i]);
    settle();

    // zero sizes act as one; NaN clamp bound
    write_reg(RegWindow, 32'd0);
    write_reg(RegChannels, 32'd0);
    write_reg(RegOutMin, QNan);
    send_sample(32'h3F80_0000);
    send_sample(32'hC000_0000);
    settle();

    // shrink the window mid-pixel
    write_reg(RegOutMin, 32'hFF80_0000);
    write_reg(RegOutMax, 32'h7F80_0000);
    write_reg(RegWindow, 32'd4);
    write_reg(RegChannels, 32'd3);
    send_pixels(2, 3, 1);
    settle();
    write_reg(RegWindow, 32'd2);
    send_pixels(1, 3, 1);
    settle();

    // lower the channel count mid-pixel
    write_reg(RegWindow, 32'd3);
    send_pixels(1, 3, 1);
    settle();
    write_reg(RegChannels, 32'd2);
    send_pixels(2, 2, 1);
    settle();

    // oversized window saturates instead of wrapping, then close the pixel
    write_reg(RegWindow, 32'd4098);
    write_reg(RegChannels, 32'd1);
    send_pixels(3, 1, 1);
    settle();
    write_reg(RegWindow, 32'd4);
    send_pixels(1, 1, 1);
    settle();

    // oversized channel count saturates instead of wrapping, then close the pixel
    write_reg(RegWindow, 32'd1);
    write_reg(RegChannels, 32'd1026);
    send_pixels(1, 3, 1);
    settle();
    write_reg(RegChannels, 32'd4);
    send_pixels(1, 1, 1);
    settle();

    // random phases with random settings, whole pixels only
    target = items_sent + 1450;
    while (items_sent < target) begin
      win = ($urandom_range(9) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      chans = ($urandom_range(6) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      write_reg(RegWindow, win);
      write_reg(RegChannels, chans);
      write_reg(RegOutMin, ($urandom_range(3) == 0) ? 32'hFF80_0000 : rand_float());
      write_reg(RegOutMax, ($urandom_range(3) == 0) ? 32'h7F80_0000 : rand_float());
      calm = (items_sent > target - 1000) && (items_sent < target - 700);
      send_pixels(win, chans, $urandom_range(1, 4));
      settle();
    end

    calm = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/mpc_pkg.sv
rtl/mpc_ram.sv
rtl/mpc_seq.sv
rtl/max_pool_clamp_f32.sv
rtl/mpc_checker.sv
verif/mpc_checker.sv
verif/tb_top.sv
